// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define SRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/srs_pkg.sv
// Shared widths, register indexes, state codes and controller/datapath bundles.
`default_nettype none

package srs_pkg;

    localparam int VALUE_W     = 32;
    localparam int ACC_W       = 48;
    localparam int CNT_W       = 16;
    localparam int FRAC_W      = 32;
    localparam int HALF_W      = ACC_W / 2;
    localparam int PROD_W      = FRAC_W + HALF_W;
    localparam int FULL_W      = FRAC_W + ACC_W;
    localparam int DIV_STEPS   = ACC_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;
    localparam int TDATA_IN_W  = 32;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 80;
    localparam int TUSER_OUT_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_NORM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAND_FRACTION = 2'd2;

    // Bit positions inside the slave tuser
    localparam int TUSER_KEEP  = 0;
    localparam int TUSER_FIRST = 1;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_MUL_LO = 6'b000100,
        S_MUL_HI = 6'b001000,
        S_SUM    = 6'b010000,
        S_EXEC   = 6'b100000
    } srs_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_item;   // capture the request fields
        logic proc_live;   // process the request on the input bus now
        logic proc_held;   // process the captured request
        logic zero_start;  // first element with zero sample count
        logic div_start;   // first element: clear sums, start divider
        logic div_step;    // one restoring division step
        logic mul_lo;      // rand * low half of step
        logic mul_hi;      // rand * high half of step
        logic thr_load;    // latch step and starting threshold
    } srs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;  // sample_count register is zero
        logic div_last;    // divider on its final step
    } srs_status_t;

    // 48-bit add that saturates at all ones
    function automatic logic [ACC_W-1:0] sat_add48(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/srs_ctrl.sv
// Controller: sequences first-element setup and drives the stream handshakes.
`default_nettype none

module srs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_first,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire srs_pkg::srs_status_t status,
    output srs_pkg::srs_cmd_t        cmd
);
    import srs_pkg::*;

    srs_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       load_out;

    // Input side free when idle and the output register is empty or draining
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    if (!in_first)
                    begin
                        cmd.proc_live = 1'b1;
                    end
                    else if (status.count_zero)
                    begin
                        cmd.zero_start = 1'b1;
                        state_next     = S_EXEC;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.thr_load = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.proc_held = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag
    assign load_out = cmd.proc_live || cmd.proc_held;

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: src/srs_datapath.sv
// Datapath: config registers, step divider, threshold multiplier, sampling logic.
`default_nettype none

module srs_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire srs_pkg::srs_cmd_t                 cmd,
    output srs_pkg::srs_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [srs_pkg::ACC_W-1:0]         cfg_data,
    input  wire logic [srs_pkg::VALUE_W-1:0]       in_value,
    input  wire logic                              in_keep,
    output logic [srs_pkg::VALUE_W-1:0]            out_value,
    output logic                                   out_zeroed,
    output logic [srs_pkg::ACC_W-1:0]              out_norm
);
    import srs_pkg::*;

    localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] NEG_MAG = {1'b1, {(VALUE_W-1){1'b0}}};

    // Configuration registers
    logic [CNT_W-1:0]  count_reg;
    logic [ACC_W-1:0]  total_reg;
    logic [FRAC_W-1:0] rand_reg;

    // Sampling state
    logic [ACC_W-1:0] bound_reg, bound_next;
    logic [ACC_W-1:0] thr_reg, thr_next;
    logic [ACC_W-1:0] step_reg;
    logic [ACC_W-1:0] norm_reg, norm_next;
    logic             no_samp_reg;

    // Captured request
    logic [VALUE_W-1:0] hold_value_reg;
    logic               hold_keep_reg;

    // Divider and multiplier
    logic [CNT_W-1:0]     rem_reg;
    logic [ACC_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [CNT_W:0]       trial;
    logic                 trial_ge;
    logic [CNT_W:0]       trial_diff;
    logic [HALF_W-1:0]    mul_b;
    logic [PROD_W-1:0]    mul_prod;
    logic [PROD_W-1:0]    pp_lo_reg, pp_hi_reg;
    logic [FULL_W-1:0]    full_prod;

    // Result path
    logic [VALUE_W-1:0] p_value;
    logic               p_keep;
    logic               p_neg;
    logic [VALUE_W-1:0] p_mag;
    logic [ACC_W-1:0]   bound_sum, thr_sum, norm_sum, norm_addend;
    logic               hit;
    logic [VALUE_W-1:0] pos_res, neg_res, res;
    logic               zeroed;

    logic [VALUE_W-1:0] out_value_reg;
    logic               out_zeroed_reg;
    logic [ACC_W-1:0]   out_norm_reg;

    assign status.count_zero = (count_reg == '0);
    assign status.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            rand_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLE_COUNT:  count_reg <= cfg_data[CNT_W-1:0];
                CFG_TOTAL_NORM:    total_reg <= cfg_data;
                CFG_RAND_FRACTION: rand_reg  <= cfg_data[FRAC_W-1:0];
                default:           ;
            endcase
        end
    end

    // Restoring divider step: one quotient bit a cycle
    assign trial      = {rem_reg, quo_reg[ACC_W-1]};
    assign trial_ge   = (trial >= {1'b0, count_reg});
    assign trial_diff = trial - {1'b0, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg     <= '0;
            quo_reg     <= total_reg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg     <= {quo_reg[ACC_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Shared multiplier: rand times one half of the quotient
    assign mul_b     = cmd.mul_hi ? quo_reg[ACC_W-1:HALF_W] : quo_reg[HALF_W-1:0];
    assign mul_prod  = {{HALF_W{1'b0}}, rand_reg} * {{FRAC_W{1'b0}}, mul_b};
    assign full_prod = {pp_hi_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pp_lo_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
        begin
            pp_lo_reg <= mul_prod;
        end
        if (cmd.mul_hi)
        begin
            pp_hi_reg <= mul_prod;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            hold_value_reg <= in_value;
            hold_keep_reg  <= in_keep;
        end
    end

    // Sampling decision for one element
    always_comb
    begin
        p_value     = cmd.proc_held ? hold_value_reg : in_value;
        p_keep      = cmd.proc_held ? hold_keep_reg : in_keep;
        p_neg       = p_value[VALUE_W-1];
        p_mag       = p_neg ? (~p_value + 1'b1) : p_value;
        bound_sum   = sat_add48(bound_reg, {{(ACC_W-VALUE_W){1'b0}}, p_mag});
        hit         = !no_samp_reg && (thr_reg < bound_sum);
        norm_addend = p_keep ? {{(ACC_W-VALUE_W){1'b0}}, p_mag} : step_reg;
        norm_sum    = sat_add48(norm_reg, norm_addend);
        thr_sum     = sat_add48(thr_reg, step_reg);
        pos_res     = (step_reg > {{(ACC_W-VALUE_W){1'b0}}, POS_MAX}) ?
                      POS_MAX : step_reg[VALUE_W-1:0];
        neg_res     = (step_reg > {{(ACC_W-VALUE_W){1'b0}}, NEG_MAG}) ?
                      NEG_MAG : (~step_reg[VALUE_W-1:0] + 1'b1);

        res        = p_value;
        zeroed     = 1'b0;
        bound_next = bound_reg;
        thr_next   = thr_reg;
        norm_next  = norm_reg;
        if (p_keep)
        begin
            norm_next = norm_sum;
        end
        else if (p_value != '0)
        begin
            bound_next = bound_sum;
            if (hit)
            begin
                res       = p_neg ? neg_res : pos_res;
                thr_next  = thr_sum;
                norm_next = norm_sum;
            end
            else
            begin
                res    = '0;
                zeroed = 1'b1;
            end
        end
    end

    // Sampling state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg   <= '0;
            thr_reg     <= '0;
            step_reg    <= '0;
            norm_reg    <= '0;
            no_samp_reg <= 1'b0;
        end
        else if (cmd.zero_start)
        begin
            bound_reg   <= '0;
            thr_reg     <= '0;
            step_reg    <= '0;
            norm_reg    <= '0;
            no_samp_reg <= 1'b1;
        end
        else if (cmd.div_start)
        begin
            bound_reg   <= '0;
            norm_reg    <= '0;
            no_samp_reg <= 1'b0;
        end
        else if (cmd.thr_load)
        begin
            step_reg <= quo_reg;
            thr_reg  <= full_prod[FULL_W-1:FRAC_W];
        end
        else if (cmd.proc_live || cmd.proc_held)
        begin
            bound_reg <= bound_next;
            thr_reg   <= thr_next;
            norm_reg  <= norm_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.proc_live || cmd.proc_held)
        begin
            out_value_reg  <= res;
            out_zeroed_reg <= zeroed;
            out_norm_reg   <= norm_next;
        end
    end

    assign out_value  = out_value_reg;
    assign out_zeroed = out_zeroed_reg;
    assign out_norm   = out_norm_reg;

endmodule

`default_nettype wire

// File: src/systematic_resample_stream_core.sv
// Top level of the streaming systematic resampling core.
`default_nettype none

// Streams a vector one element per request and compresses it by systematic
// resampling in Q16.16. An element without the first flag is processed as it
// is taken. A new request is taken every cycle while no setup runs and the
// result side keeps up. A result that waits in the output register holds off
// the input, and the next request is taken in the cycle that the waiting
// result leaves. An element with the first flag is captured and then
// processed when sample_count is zero; otherwise the bit-serial step division
// total_norm / sample_count, the 32x24 multiplier on the low and then the
// high half of the step, and the sum of the partial products that forms the
// starting threshold come between. Write configuration only while the core
// is idle; new values take effect at the next first element.
module systematic_resample_stream_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [srs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [srs_pkg::ACC_W-1:0]          cfg_data,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [srs_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [31:0] value
    input  wire logic [srs_pkg::TUSER_IN_W-1:0]     s_axis_tuser,  // [0] keep_exact_in, [1] first_element
    input  wire logic                               s_axis_tlast,  // last_element
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [srs_pkg::TDATA_OUT_W-1:0]         m_axis_tdata,  // [31:0] out_value, [79:32] norm_sum
    output logic [srs_pkg::TUSER_OUT_W-1:0]         m_axis_tuser,  // [0] zeroed_flag
    output logic                                    m_axis_tlast   // last_out
);
    import srs_pkg::*;

    srs_cmd_t           cmd;
    srs_status_t        status;
    logic [VALUE_W-1:0] out_value;
    logic               out_zeroed;
    logic [ACC_W-1:0]   out_norm;
    logic               last_reg;

    srs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_first  (s_axis_tuser[TUSER_FIRST]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    srs_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_value   (s_axis_tdata[VALUE_W-1:0]),
        .in_keep    (s_axis_tuser[TUSER_KEEP]),
        .out_value  (out_value),
        .out_zeroed (out_zeroed),
        .out_norm   (out_norm)
    );

    // Frame marker follows the request into the output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            last_reg <= s_axis_tlast;
        end
    end

    assign m_axis_tdata = {out_norm, out_value};
    assign m_axis_tuser = out_zeroed;
    assign m_axis_tlast = last_reg;

endmodule

`default_nettype wire

// File: src/srs_checker.sv
// Port-level checker for the resampling core, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module srs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [srs_pkg::TUSER_IN_W-1:0]    s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [srs_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    input wire logic [srs_pkg::TUSER_OUT_W-1:0]   m_axis_tuser
);
    import srs_pkg::*;

    // A stalled result stays offered
    `SRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // Input is only taken when the output register can receive
    `SRS_ASSERT_IMPL(a_ready_room, s_axis_tready, !m_axis_tvalid || m_axis_tready, "ready with full output register")

    // A non-first request produces its result on the next cycle
    `SRS_ASSERT_NEXT(a_fast_path, s_axis_tvalid && s_axis_tready && !s_axis_tuser[TUSER_FIRST], m_axis_tvalid, "non-first request result late")

    // A first request holds off further input while setting up
    `SRS_ASSERT_NEXT(a_first_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser[TUSER_FIRST], !s_axis_tready, "request taken during setup")

    // A zeroed element carries a zero value
    `SRS_ASSERT_IMPL(a_zeroed_val, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[VALUE_W-1:0] == '0, "zeroed flag with nonzero value")

endmodule

bind systematic_resample_stream_core srs_checker u_srs_checker (.*);

`default_nettype wire

// File: dv/tb_systematic_resample_stream_core.sv
// Testbench for the streaming systematic resampling core: directed and random vectors checked against a predictor.
`timescale 1ns / 100ps

module tb_systematic_resample_stream_core;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SEGMENT_ITEMS = 68;

    // One input element and one compressed result
    typedef struct {
        logic [31:0] value;
        logic        keep;
        logic        first;
        logic        last;
    } element_t;

    typedef struct {
        logic [31:0] value;
        logic        zeroed;
        logic [47:0] norm;
        logic        last;
    } resample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_we = 1'b0;
    logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [srs_pkg::ACC_W-1:0]         cfg_data = '0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [srs_pkg::TDATA_IN_W-1:0]    s_axis_tdata = '0;   // [31:0] value
    logic [srs_pkg::TUSER_IN_W-1:0]    s_axis_tuser = '0;   // [0] keep_exact_in, [1] first_element
    logic                              s_axis_tlast = 1'b0; // last_element

    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [srs_pkg::TDATA_OUT_W-1:0]   m_axis_tdata;        // [31:0] out_value, [79:32] norm_sum
    logic [srs_pkg::TUSER_OUT_W-1:0]   m_axis_tuser;        // [0] zeroed_flag
    logic                              m_axis_tlast;        // last_out

    systematic_resample_stream_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Register mirror and predictor state
    logic [15:0] reg_count = '0;
    logic [47:0] reg_total = '0;
    logic [31:0] reg_frac = '0;
    logic [47:0] p_bound = '0;
    logic [47:0] p_thresh = '0;
    logic [47:0] p_step = '0;
    logic [47:0] p_norm = '0;
    logic        p_off = 1'b0;

    element_t    pending_elems[$];
    resample_t   expected_results[$];
    element_t    drive_elem;
    logic [srs_pkg::TUSER_IN_W-1:0] drive_user;
    resample_t   want;

    int          send_idle = 0;
    int          recv_stall = 0;
    int unsigned cycle_count = 0;
    int unsigned n_fail = 0;
    int unsigned n_items = 0;
    int unsigned n_results = 0;
    int unsigned n_zeroed = 0;
    int unsigned n_vectors = 0;
    int unsigned n_settings = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // 48-bit unsigned add, clipped at all ones
    function automatic logic [47:0] sum_clip48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    // Predict the result of one accepted element and advance the state
    function automatic resample_t resample_element(input logic [31:0] v, input logic keep,
                                                   input logic first, input logic last);
        resample_t   r;
        logic        neg;
        logic [47:0] mag;
        logic [47:0] lim;
        logic [47:0] wrapped;
        logic [79:0] prod;
        neg = v[31];
        mag = neg ? (48'h1_0000_0000 - {16'd0, v}) : {16'd0, v};
        r.value = v;
        r.zeroed = 1'b0;
        r.last = last;
        if (first)
        begin
            p_bound = '0;
            p_norm = '0;
            if (reg_count == 16'd0)
            begin
                p_off = 1'b1;
                p_step = '0;
                p_thresh = '0;
            end
            else
            begin
                p_off = 1'b0;
                p_step = reg_total / {32'd0, reg_count};
                prod = {48'd0, reg_frac} * {32'd0, p_step};
                p_thresh = prod[79:32];
            end
        end
        if (keep)
            p_norm = sum_clip48(p_norm, mag);
        else if (v != 32'd0)
        begin
            p_bound = sum_clip48(p_bound, mag);
            if (!p_off && p_thresh < p_bound)
            begin
                // sampled: +/- one step, clipped to the output range
                if (neg)
                begin
                    lim = (p_step > 48'h8000_0000) ? 48'h8000_0000 : p_step;
                    wrapped = 48'h1_0000_0000 - lim;
                    r.value = wrapped[31:0];
                end
                else
                begin
                    lim = (p_step > 48'h7FFF_FFFF) ? 48'h7FFF_FFFF : p_step;
                    r.value = lim[31:0];
                end
                p_thresh = sum_clip48(p_thresh, p_step);
                p_norm = sum_clip48(p_norm, p_step);
            end
            else
            begin
                r.value = '0;
                r.zeroed = 1'b1;
            end
        end
        r.norm = p_norm;
        return r;
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                drive_elem = pending_elems.pop_front();
                drive_user = '0;
                drive_user[srs_pkg::TUSER_KEEP] = drive_elem.keep;
                drive_user[srs_pkg::TUSER_FIRST] = drive_elem.first;
                s_axis_tdata <= drive_elem.value;
                s_axis_tuser <= drive_user;
                s_axis_tlast <= drive_elem.last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    task automatic report(input string field, input logic [47:0] exp_v, input logic [47:0] act_v);
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, exp_v, act_v);
        n_fail++;
    endtask

    // Result checker and request monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (m_axis_tuser[0])
                    n_zeroed++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected: expected nothing, got %h",
                             $time, m_axis_tdata);
                    n_fail++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.value)
                        report("out_value", {16'd0, want.value}, {16'd0, m_axis_tdata[31:0]});
                    if (m_axis_tuser[0] !== want.zeroed)
                        report("zeroed_flag", {47'd0, want.zeroed}, {47'd0, m_axis_tuser[0]});
                    if (m_axis_tdata[79:32] !== want.norm)
                        report("norm_sum", want.norm, m_axis_tdata[79:32]);
                    if (m_axis_tlast !== want.last)
                        report("last_out", {47'd0, want.last}, {47'd0, m_axis_tlast});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_items++;
                expected_results.push_back(resample_element(s_axis_tdata,
                    s_axis_tuser[srs_pkg::TUSER_KEEP], s_axis_tuser[srs_pkg::TUSER_FIRST],
                    s_axis_tlast));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [srs_pkg::CFG_IDX_W-1:0] idx, input logic [47:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            srs_pkg::CFG_SAMPLE_COUNT:  reg_count = data[15:0];
            srs_pkg::CFG_TOTAL_NORM:    reg_total = data;
            srs_pkg::CFG_RAND_FRACTION: reg_frac = data[31:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold off until every request is sent and every result has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_elems.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic push_elem(input logic [31:0] v, input logic keep, input logic first,
                             input logic last);
        element_t e;
        e.value = v;
        e.keep = keep;
        e.first = first;
        e.last = last;
        pending_elems.push_back(e);
        if (first)
            n_vectors++;
    endtask

    task automatic set_regs(input logic [15:0] cnt, input logic [47:0] tot, input logic [31:0] frac);
        write_reg(srs_pkg::CFG_SAMPLE_COUNT, {32'd0, cnt});
        write_reg(srs_pkg::CFG_TOTAL_NORM, tot);
        write_reg(srs_pkg::CFG_RAND_FRACTION, {16'd0, frac});
        n_settings++;
    endtask

    // Random settings; the magnitude scale keeps the step near the element sizes
    task automatic pick_settings(output int unsigned mag_max);
        int unsigned kind;
        logic [63:0] wide;
        logic [47:0] tot;
        kind = $urandom_range(9);
        mag_max = 1 << $urandom_range(8, 30);
        wide = {$urandom, $urandom};
        case (kind)
            0: set_regs(16'd0, wide[47:0], $urandom);
            1:
            begin
                tot = $urandom_range(1) ? 48'hFFFF_FFFF_FFFF : wide[47:0];
                set_regs($urandom_range(1) ? 16'd1 : 16'hFFFF, tot,
                         $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF);
            end
            default:
            begin
                tot = 48'($urandom_range(4, 16)) * 48'(mag_max >> 1);
                set_regs(16'($urandom_range(1, 12)), tot, $urandom);
            end
        endcase
    endtask

    // One vector, well formed except for occasional flipped frame marks
    task automatic push_vector(input int unsigned mag_max, output int unsigned len);
        int unsigned roll;
        int unsigned m;
        logic [31:0] v;
        logic        f;
        logic        l;
        logic        k;
        len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 24);
        for (int i = 0; i < len; i++)
        begin
            f = (i == 0);
            l = (i == len - 1);
            roll = $urandom_range(39);
            if (roll == 0)
                f = ~f;
            else if (roll == 1)
                l = ~l;
            roll = $urandom_range(99);
            if (roll < 10)
                v = '0;
            else if (roll < 15)
                v = $urandom;
            else
            begin
                m = $urandom_range(1, mag_max);
                v = $urandom_range(1) ? (~m + 32'd1) : m;
            end
            k = ($urandom_range(99) < 10);
            push_elem(v, k, f, l);
        end
    endtask

    initial
    begin
        int unsigned mag_max;
        int unsigned len;
        int unsigned seg_items;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Before any first element: state straight from reset
        push_elem(32'h0001_0000, 1'b0, 1'b0, 1'b0);
        push_elem(32'h8000_0000, 1'b0, 1'b0, 1'b0);
        push_elem(32'hFFFF_0000, 1'b1, 1'b0, 1'b0);
        push_elem(32'h0000_0000, 1'b0, 1'b0, 1'b1);
        wait_idle();

        // Zero sample count: every sampled element is zeroed
        set_regs(16'd0, 48'h1234_5678_9ABC, 32'h8000_0000);
        push_elem(32'h0005_0000, 1'b0, 1'b1, 1'b0);
        push_elem(32'hFFFD_0000, 1'b0, 1'b0, 1'b0);
        push_elem(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
        push_elem(32'h0000_0000, 1'b0, 1'b0, 1'b0);
        push_elem(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
        wait_idle();

        // Step too wide for the output, and norm clipping
        set_regs(16'd1, 48'hFFFF_FFFF_FFFF, 32'd0);
        push_elem(32'h8000_0000, 1'b0, 1'b1, 1'b0);
        push_elem(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
        push_elem(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
        push_elem(32'h0000_0001, 1'b0, 1'b0, 1'b1);
        wait_idle();

        // Largest count and fraction; vector left open across a register write
        set_regs(16'hFFFF, 48'h0000_FFFF_0000, 32'hFFFF_FFFF);
        push_elem(32'h0000_8000, 1'b0, 1'b1, 1'b0);
        push_elem(32'h0000_8000, 1'b0, 1'b0, 1'b0);
        push_elem(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        push_elem(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
        wait_idle();
        write_reg(srs_pkg::CFG_SAMPLE_COUNT, 48'd2);
        push_elem(32'h0001_0000, 1'b0, 1'b0, 1'b0);
        push_elem(32'h8000_0000, 1'b1, 1'b0, 1'b1);
        push_elem(32'h4000_0000, 1'b0, 1'b1, 1'b1);

        // Random vectors under four idle profiles
        for (int mode = 0; mode < 4; mode++)
        begin
            for (int seg = 0; seg < 6; seg++)
            begin
                wait_idle();
                case (mode)
                    0: begin send_idle = 0;  recv_stall = 0;  end
                    1: begin send_idle = 77; recv_stall = 0;  end
                    2: begin send_idle = 0;  recv_stall = 77; end
                    default: begin send_idle = 28; recv_stall = 28; end
                endcase
                pick_settings(mag_max);
                seg_items = 0;
                while (seg_items < SEGMENT_ITEMS)
                begin
                    push_vector(mag_max, len);
                    seg_items += len;
                end
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            n_fail++;
        end
        $display("Sent %0d elements in %0d vectors under %0d register settings.",
                 n_items, n_vectors, n_settings);
        $display("Checked %0d results, %0d zeroed by sampling, %0d mismatches.",
                 n_results, n_zeroed, n_fail);
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/srs_pkg.sv
src/srs_ctrl.sv
src/srs_datapath.sv
src/systematic_resample_stream_core.sv
src/srs_checker.sv
dv/tb_systematic_resample_stream_core.sv
